[rtl/pixel_channel_depth_convert_top_macros.svh]
// Assertion macros for the RTL that checks itself.
`ifndef PIXEL_CHANNEL_DEPTH_CONVERT_TOP_MACROS_SVH
`define PIXEL_CHANNEL_DEPTH_CONVERT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCDC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcdc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcdc assertion failed");

`endif

[rtl/pcdc_pkg.sv]
`default_nettype none
package pcdc_pkg;

	localparam int CHAN_W        = 8;
	localparam int DEPTH_W       = 4;
	localparam int NUM_CHAN      = 4;
	localparam int NUM_REGS      = 2 * NUM_CHAN;
	localparam int REG_IDX_W     = $clog2(NUM_REGS);
	localparam int ADDR_W        = REG_IDX_W + 2;
	localparam int APB_DATA_W    = 32;
	localparam int MAX_DEPTH_DEF = 8;
	localparam int RESET_DEPTH   = 8;

	// Register map: source depths first, then destination depths, in channel order.
	localparam int SRC_BASE = 0;
	localparam int DST_BASE = NUM_CHAN;

	// Channel order inside a pixel.
	localparam int CH_ALPHA = 0;
	localparam int CH_RED   = 1;
	localparam int CH_GREEN = 2;
	localparam int CH_BLUE  = 3;

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	typedef struct packed {
		depth_t src;
		depth_t dst;
	} pcdc_depth_t;

	typedef struct packed {
		chan_t in_alpha;
		chan_t in_red;
		chan_t in_green;
		chan_t in_blue;
	} pcdc_in_t;

	typedef struct packed {
		chan_t out_alpha;
		chan_t out_red;
		chan_t out_green;
		chan_t out_blue;
	} pcdc_out_t;

endpackage
`default_nettype wire

[rtl/pixel_channel_depth_convert_top.sv]
// Pixel channel depth converter.
// A request is one pixel of four channels (alpha, red, green, blue) on in_pixel,
// taken at a rising edge where start is high and busy is low. busy never rises,
// so a new request may be presented in every cycle: one pixel per clock.
// Each channel runs through its own conversion lane, set by its source and
// destination depth registers; equal depths pass, a zero source depth gives all
// ones, widening replicates the source bits and narrowing rounds and saturates.
// The lane outputs are gathered into one result register, so result and
// result_valid appear in the cycle after the request; each strobe lasts one cycle.
// The receiver cannot stall; a result not taken in its cycle is gone.
// The result register after the lanes is the only register on the data path.
// The eight depth registers live on the APB port, one per word, source depths
// at 0x00-0x0C and destination depths at 0x10-0x1C, 4 bits each, reset to 8.
// Write them only while no request is in flight.
// Reset (arst_n low) clears the result strobe and sets every depth back to 8.
`default_nettype none
`include "pixel_channel_depth_convert_top_macros.svh"
module pixel_channel_depth_convert_top #(
	parameter int MAX_DEPTH = pcdc_pkg::MAX_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [pcdc_pkg::ADDR_W-1:0]           paddr,
	input  logic [pcdc_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [pcdc_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready,
	input  logic                                  start,
	output logic                                  busy,
	input  pcdc_pkg::pcdc_in_t                    in_pixel,
	output logic                                  result_valid,
	output pcdc_pkg::pcdc_out_t                   result
);
	import pcdc_pkg::*;

	depth_t                   depth_q [NUM_REGS];
	logic [REG_IDX_W-1:0]     reg_idx;
	logic                     cfg_wr;
	logic                     take;
	chan_t [NUM_CHAN-1:0]     lane_in;
	chan_t [NUM_CHAN-1:0]     lane_res;

	// The APB port has no wait states. The low two address bits select a byte
	// within the word and are not decoded.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = APB_DATA_W'(depth_q[reg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				depth_q[i] <= DEPTH_W'(RESET_DEPTH);
		end else if (cfg_wr) begin
			depth_q[reg_idx] <= pwdata[DEPTH_W-1:0];
		end
	end

	// Every lane is combinational, so the converter is always free.
	assign busy = 1'b0;
	assign take = start && !busy;

	assign lane_in[CH_ALPHA] = in_pixel.in_alpha;
	assign lane_in[CH_RED]   = in_pixel.in_red;
	assign lane_in[CH_GREEN] = in_pixel.in_green;
	assign lane_in[CH_BLUE]  = in_pixel.in_blue;

	// One conversion lane per channel, each fed by its own pair of depth registers.
	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
		pcdc_depth_t lane_depth;
		assign lane_depth.src = depth_q[SRC_BASE + c];
		assign lane_depth.dst = depth_q[DST_BASE + c];

		pcdc_lane #(
			.MAX_DEPTH (MAX_DEPTH)
		) u_lane (
			.val   (lane_in[c]),
			.depth (lane_depth),
			.conv  (lane_res[c])
		);
	end

	// The merge stage packs the four lane results into one registered pixel.
	pcdc_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.lane_res     (lane_res),
		.result_valid (result_valid),
		.result       (result)
	);

	// Every accepted request yields a result in the next cycle, and no other.
	`PCDC_ASSERT_NEXT(a_req_gives_result, take, result_valid)
	`PCDC_ASSERT_NEXT(a_no_spurious_result, !take, !result_valid)
	// Equal red depths pass the red value through unchanged.
	`PCDC_ASSERT_NEXT(a_red_passthrough, take && (depth_q[SRC_BASE + CH_RED] == depth_q[DST_BASE + CH_RED]), result.out_red == $past(in_pixel.in_red))
	// A zero alpha source depth into a full-depth destination gives opaque alpha.
	`PCDC_ASSERT_NEXT(a_alpha_zero_src, take && (depth_q[SRC_BASE + CH_ALPHA] == '0) && (depth_q[DST_BASE + CH_ALPHA] == DEPTH_W'(MAX_DEPTH)), result.out_alpha == ((CHAN_W+1)'(1) << MAX_DEPTH) - (CHAN_W+1)'(1))

endmodule
`default_nettype wire

[rtl/pcdc_lane.sv]
`default_nettype none
module pcdc_lane #(
	parameter int MAX_DEPTH = pcdc_pkg::MAX_DEPTH_DEF
) (
	input  pcdc_pkg::chan_t      val,
	input  pcdc_pkg::pcdc_depth_t depth,
	output pcdc_pkg::chan_t      conv
);
	import pcdc_pkg::*;

	depth_t             from_d;
	depth_t             to_d;
	depth_t             drop;
	chan_t              pat_top;
	chan_t              rep;
	chan_t              widened;
	logic [CHAN_W:0]    ones;
	logic [CHAN_W:0]    sum;
	logic [CHAN_W:0]    narrowed;
	logic [6:0]         rep_sh;

	always_comb begin
		// Depths above the supported maximum act as the maximum.
		from_d = (depth.src > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth.src;
		to_d   = (depth.dst > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth.dst;
		ones   = ((CHAN_W+1)'(1) << to_d) - (CHAN_W+1)'(1);

		// Widening: left-align the source bits, then OR in copies shifted down by
		// whole multiples of the source depth to get the MSB-first repetition.
		pat_top = val << (DEPTH_W'(CHAN_W) - from_d);
		rep     = pat_top;
		for (int k = 1; k < CHAN_W; k++) begin
			rep_sh = 7'(from_d) * 7'(k);
			if (rep_sh < 7'(CHAN_W))
				rep = rep | (pat_top >> rep_sh);
		end
		widened = rep >> (DEPTH_W'(CHAN_W) - to_d);

		// Narrowing: round half up, drop the low bits, saturate.
		drop     = from_d - to_d;
		sum      = {1'b0, val} + ((CHAN_W+1)'(1) << (drop - DEPTH_W'(1)));
		narrowed = sum >> drop;

		if (from_d == to_d)
			conv = val;
		else if (from_d == '0)
			conv = ones[CHAN_W-1:0];
		else if (to_d > from_d)
			conv = widened;
		else if (to_d == '0)
			conv = '1;
		else if (narrowed > ones)
			conv = ones[CHAN_W-1:0];
		else
			conv = narrowed[CHAN_W-1:0];
	end

endmodule
`default_nettype wire

[rtl/pcdc_merge.sv]
`default_nettype none
module pcdc_merge (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       take,
	input  pcdc_pkg::chan_t [pcdc_pkg::NUM_CHAN-1:0]   lane_res,
	output logic                                       result_valid,
	output pcdc_pkg::pcdc_out_t                        result
);
	import pcdc_pkg::*;

	logic      valid_s1;
	pcdc_out_t pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1.out_alpha <= lane_res[CH_ALPHA];
			pix_s1.out_red   <= lane_res[CH_RED];
			pix_s1.out_green <= lane_res[CH_GREEN];
			pix_s1.out_blue  <= lane_res[CH_BLUE];
		end
	end

	assign result_valid = valid_s1;
	assign result       = pix_s1;

endmodule
`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

// Testbench for the pixel channel depth converter.
//
// A queue of pending pixels is filled by the sequencing initial block. A
// clocked driver presents them as requests with random gaps. At every accepted
// request it predicts the converted pixel from its own copy of the eight depth
// registers and appends it to a queue of expected pixels. A clocked monitor
// compares every result strobe with the oldest expected pixel, channel by
// channel. Depth registers are rewritten over APB only while nothing is in
// flight, so the copy used for prediction is always the one the block uses.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pcdc_pkg::*;

	// Register values above this are treated as this depth.
	localparam int DEPTH_CAP = MAX_DEPTH_DEF;
	// Cycles without any request, result or register write before giving up.
	localparam int QUIET_LIMIT = 2000;
	// Least number of random requests to issue after the directed part.
	localparam int RANDOM_REQUESTS = 1050;
	// Phase of the random part that runs with no gaps at all.
	localparam int GAPLESS_PHASE = 6;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [ADDR_W-1:0]     paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  start    = 1'b0;
	logic                  busy;
	pcdc_in_t              in_pixel = '0;
	logic                  result_valid;
	pcdc_out_t             result;

	// Depth settings as the block holds them, alpha at index CH_ALPHA.
	depth_t    src_depth_copy [NUM_CHAN] = '{default: depth_t'(RESET_DEPTH)};
	depth_t    dst_depth_copy [NUM_CHAN] = '{default: depth_t'(RESET_DEPTH)};

	pcdc_in_t  pixel_queue [$];
	pcdc_out_t expected_pixels [$];
	pcdc_out_t wanted_pixel;

	bit        gapless        = 1'b0;
	int        mismatch_count = 0;
	int        quiet_cycles   = 0;

	pixel_channel_depth_convert_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.in_pixel    (in_pixel),
		.result_valid(result_valid),
		.result      (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned capped_depth(depth_t raw);
		return (raw > DEPTH_CAP) ? DEPTH_CAP : int'(raw);
	endfunction

	// Converts one channel value between two depths.
	function automatic chan_t convert_depth(chan_t value, depth_t from_raw, depth_t to_raw);
		int unsigned from_d;
		int unsigned to_d;
		int unsigned bits;
		int unsigned drop;
		logic [31:0] pattern;
		logic [31:0] acc;
		logic [31:0] top;
		from_d = capped_depth(from_raw);
		to_d   = capped_depth(to_raw);
		// Equal depths pass the whole 8-bit value, stray high bits included.
		if (from_d == to_d)
			return value;
		// No source bits at all: full scale at the destination depth.
		if (from_d == 0)
			return chan_t'((32'd1 << to_d) - 1);
		if (to_d > from_d) begin
			// Widening repeats the source pattern MSB first, then keeps the top bits.
			pattern = 32'(value) & ((32'd1 << from_d) - 1);
			acc     = pattern;
			bits    = from_d;
			while (bits < to_d) begin
				acc  = (acc << from_d) | pattern;
				bits = bits + from_d;
			end
			return chan_t'(acc >> (bits - to_d));
		end
		if (to_d == 0)
			return 8'hFF;
		// Narrowing rounds half up on the full input and saturates.
		drop = from_d - to_d;
		acc  = (32'(value) + (32'd1 << (drop - 1))) >> drop;
		top  = (32'd1 << to_d) - 1;
		return chan_t'((acc > top) ? top : acc);
	endfunction

	function automatic pcdc_out_t predict_pixel(pcdc_in_t px);
		chan_t ch_in  [NUM_CHAN];
		chan_t ch_out [NUM_CHAN];
		{ch_in[CH_ALPHA], ch_in[CH_RED], ch_in[CH_GREEN], ch_in[CH_BLUE]} = px;
		for (int c = 0; c < NUM_CHAN; c++)
			ch_out[c] = convert_depth(ch_in[c], src_depth_copy[c], dst_depth_copy[c]);
		return {ch_out[CH_ALPHA], ch_out[CH_RED], ch_out[CH_GREEN], ch_out[CH_BLUE]};
	endfunction

	// Mostly values that fit the source depth, with full-range values mixed in
	// so that stray high bits and saturation are reached as well.
	function automatic pcdc_in_t random_pixel();
		chan_t       ch [NUM_CHAN];
		int unsigned d;
		int unsigned pick;
		for (int c = 0; c < NUM_CHAN; c++) begin
			d    = capped_depth(src_depth_copy[c]);
			pick = $urandom_range(0, 99);
			if (pick < 55)
				ch[c] = chan_t'($urandom() & ((32'd1 << d) - 1));
			else if (pick < 65)
				ch[c] = chan_t'((32'd1 << d) - 1);
			else if (pick < 70)
				ch[c] = 8'hFF;
			else
				ch[c] = chan_t'($urandom_range(0, 255));
		end
		return {ch[CH_ALPHA], ch[CH_RED], ch[CH_GREEN], ch[CH_BLUE]};
	endfunction

	// Four depths in one word, alpha in the top nibble. Values above the cap
	// show up now and then to exercise the clamping.
	function automatic logic [NUM_CHAN*DEPTH_W-1:0] random_depths();
		logic [NUM_CHAN*DEPTH_W-1:0] set;
		for (int c = 0; c < NUM_CHAN; c++) begin
			if ($urandom_range(0, 99) < 12)
				set[c*DEPTH_W +: DEPTH_W] = depth_t'($urandom_range(DEPTH_CAP + 1, 15));
			else
				set[c*DEPTH_W +: DEPTH_W] = depth_t'($urandom_range(0, DEPTH_CAP));
		end
		return set;
	endfunction

	// One APB write: setup cycle, then access until pready. The upper data
	// bits carry noise since only the low nibble is a depth.
	task automatic write_depth(int unsigned reg_idx, depth_t value);
		logic [APB_DATA_W-1:0] word;
		word                = $urandom();
		word[DEPTH_W-1:0]   = value;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(reg_idx * 4);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx < DST_BASE)
			src_depth_copy[reg_idx - SRC_BASE] = value;
		else
			dst_depth_copy[reg_idx - DST_BASE] = value;
	endtask

	// Writes all eight registers; nibbles are alpha, red, green, blue from the top.
	task automatic load_depths(logic [NUM_CHAN*DEPTH_W-1:0] src_set,
	                           logic [NUM_CHAN*DEPTH_W-1:0] dst_set);
		for (int c = 0; c < NUM_CHAN; c++)
			write_depth(SRC_BASE + c, src_set[(NUM_CHAN-1-c)*DEPTH_W +: DEPTH_W]);
		for (int c = 0; c < NUM_CHAN; c++)
			write_depth(DST_BASE + c, dst_set[(NUM_CHAN-1-c)*DEPTH_W +: DEPTH_W]);
	endtask

	// Waits until every request went out and every result came back, then
	// waits out the settle argument. Checked at the falling edge, where the
	// clocked processes have all settled.
	task automatic wait_drained(int unsigned settle);
		@(negedge clk);
		while (pixel_queue.size() != 0 || start || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Extremes of every channel: all zeros, all ones, the values around the
	// midpoint and next to the extremes, and mixed nibble patterns.
	task automatic push_directed_pixels();
		@(negedge clk);
		pixel_queue.push_back(pcdc_in_t'(32'h0000_0000));
		pixel_queue.push_back(pcdc_in_t'(32'hFFFF_FFFF));
		pixel_queue.push_back(pcdc_in_t'(32'h807F_01FE));
		pixel_queue.push_back(pcdc_in_t'(32'h5AA5_C33C));
	endtask

	task automatic check_channel(string name, chan_t want, chan_t got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Sequencing: reset, a directed part, then random phases, each phase
	// starting with a fresh set of depth registers while the block is idle.
	initial begin
		int unsigned issued;
		int unsigned phase;
		int unsigned count;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset depths: every channel passes 8 bits straight through.
		push_directed_pixels();
		wait_drained(2);
		// Zero source to full scale, widening 3 to 8, narrowing with
		// saturation 8 to 3, and a zero destination.
		load_depths(16'h0388, 16'h5830);
		push_directed_pixels();
		wait_drained(2);
		// Both depths zero with stray bits, both depths above the cap,
		// widening from a single bit, and narrowing with stray high bits.
		load_depths(16'h0C15, 16'h0F72);
		push_directed_pixels();
		wait_drained(2);
		// Clamped source narrowed to 4, widening into a clamped destination,
		// narrowing to one bit, and widening by a non-multiple.
		load_depths(16'hF274, 16'h4D16);
		push_directed_pixels();
		wait_drained(2);

		issued = 0;
		phase  = 0;
		while (issued < RANDOM_REQUESTS) begin
			case (phase)
				0: load_depths(16'h0000, 16'h8888);
				1: load_depths(16'h8888, 16'h0000);
				2: load_depths(16'h1111, 16'h8888);
				3: load_depths(16'h8888, 16'h1111);
				4: load_depths(16'hFFFF, 16'h9ABF);
				default: load_depths(random_depths(), random_depths());
			endcase
			count = (phase == GAPLESS_PHASE) ? 200 : $urandom_range(25, 60);
			@(negedge clk);
			gapless = (phase == GAPLESS_PHASE);
			for (int n = 0; n < count; n++)
				pixel_queue.push_back(random_pixel());
			issued = issued + count;
			wait_drained(2);
			phase++;
		end

		wait_drained(4);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Request driver. A presented pixel is held until accepted; between
	// requests the pixel bus carries noise that the block must ignore.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			in_pixel <= '0;
		end else begin
			if (start && !busy) begin
				expected_pixels.push_back(predict_pixel(in_pixel));
				void'(pixel_queue.pop_front());
			end
			if (!(start && busy)) begin
				if (pixel_queue.size() != 0 && (gapless || $urandom_range(0, 99) >= 10)) begin
					start    <= 1'b1;
					in_pixel <= pixel_queue[0];
				end else begin
					start    <= 1'b0;
					in_pixel <= pcdc_in_t'($urandom());
				end
			end
		end
	end

	// Result monitor. A strobe lasts one cycle and cannot be held off, so
	// every strobe seen at an edge is a result taken.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t ns: result %08h with no request outstanding, expected none",
				         $time, result);
				mismatch_count++;
			end else begin
				wanted_pixel = expected_pixels.pop_front();
				check_channel("alpha", wanted_pixel.out_alpha, result.out_alpha);
				check_channel("red",   wanted_pixel.out_red,   result.out_red);
				check_channel("green", wanted_pixel.out_green, result.out_green);
				check_channel("blue",  wanted_pixel.out_blue,  result.out_blue);
			end
		end
	end

	// Watchdog: any request, result or register access counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

`default_nettype wire

[pixel_channel_depth_convert_top.f]
+incdir+rtl
rtl/pcdc_pkg.sv
rtl/pcdc_lane.sv
rtl/pcdc_merge.sv
rtl/pixel_channel_depth_convert_top.sv
sim/tb_top.sv
